@@ rtl/dcmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmc_pkg
// Shared types and widths for the discrete curve max curvature block.
// ----------------------------------------------------------------------------
package dcmc_pkg;

  localparam int COORD_W = 32;   // Q16.16 point coordinate
  localparam int SLOPE_W = 34;   // first difference, units of 2^-17
  localparam int CURV_W  = 36;   // second difference, units of 2^-18
  localparam int RES_W   = 32;   // unsigned Q16.16 curvature

  // serial multiplier operand and product widths
  localparam int MCAND_W = 136;  // up to D^2
  localparam int MPLR_W  = 70;   // up to N
  localparam int PROD_W  = MCAND_W + MPLR_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0] max_curvature;
    logic             too_few_points;
  } out_item_t;

  // one unit of work for the back end
  typedef struct packed {
    logic signed [SLOPE_W-1:0] a;      // x'
    logic signed [SLOPE_W-1:0] b;      // y'
    logic signed [CURV_W-1:0]  c;      // x''
    logic signed [CURV_W-1:0]  e;      // y''
    logic                      curv;   // evaluate curvature
    logic                      emit;   // deliver result afterwards
    logic                      few;    // curve too short
  } job_t;

endpackage

@@ rtl/dcmc_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmc_fifo
// Small job queue between front end and back end.
// ----------------------------------------------------------------------------
module dcmc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dcmc_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output dcmc_pkg::job_t  pop_job,
  output logic            empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dcmc_pkg::job_t   mem_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("job queue underflow");
`endif

endmodule

@@ rtl/dcmc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmc_front
// Point windows and difference windows; turns points into curvature jobs.
// ----------------------------------------------------------------------------
module dcmc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dcmc_pkg::in_item_t   in_item,
  output logic                 push,
  output dcmc_pkg::job_t       push_job,
  input  logic                 full
);

  localparam logic [1:0] PH_IN  = 2'd0;  // taking points
  localparam logic [1:0] PH_END = 2'd1;  // end difference of last point
  localparam logic [1:0] PH_FIN = 2'd2;  // final curvature, then clear

  localparam int SW = dcmc_pkg::SLOPE_W;
  localparam int CW = dcmc_pkg::CURV_W;

  logic signed [dcmc_pkg::COORD_W-1:0] xw_r [3];
  logic signed [dcmc_pkg::COORD_W-1:0] yw_r [3];
  logic signed [SW-1:0]                xs_r [3];
  logic signed [SW-1:0]                ys_r [3];
  logic [1:0]                          pts_r;
  logic [1:0]                          phase_r;

  logic              accept;
  logic              few;
  logic signed [SW-1:0] dx_mid, dy_mid, dx_two, dy_two, dx_end, dy_end;
  logic signed [CW-1:0] c_in, e_in, c_end, e_end, c_fin, e_fin;

  assign in_stall = (phase_r != PH_IN) || full;
  assign accept   = in_valid && !in_stall;
  assign few      = in_item.last_point && !pts_r[1];

  // inside difference of the previous point, and the one-sided start
  assign dx_mid = SW'(in_item.x_coord) - SW'(xw_r[1]);
  assign dy_mid = SW'(in_item.y_coord) - SW'(yw_r[1]);
  assign dx_two = (SW'(in_item.x_coord) - SW'(xw_r[2])) <<< 1;
  assign dy_two = (SW'(in_item.y_coord) - SW'(yw_r[2])) <<< 1;
  // one-sided end difference (last point already in the window)
  assign dx_end = (SW'(xw_r[2]) - SW'(xw_r[1])) <<< 1;
  assign dy_end = (SW'(yw_r[2]) - SW'(yw_r[1])) <<< 1;

  // second differences after the new slope enters at the top
  always_comb begin
    if (pts_r == 2'd2) begin
      c_in = (CW'(dx_mid) - CW'(xs_r[2])) <<< 1;
      e_in = (CW'(dy_mid) - CW'(ys_r[2])) <<< 1;
    end else begin
      c_in = CW'(dx_mid) - CW'(xs_r[1]);
      e_in = CW'(dy_mid) - CW'(ys_r[1]);
    end
  end
  assign c_end = CW'(dx_end) - CW'(xs_r[1]);
  assign e_end = CW'(dy_end) - CW'(ys_r[1]);
  assign c_fin = (CW'(xs_r[2]) - CW'(xs_r[1])) <<< 1;
  assign e_fin = (CW'(ys_r[2]) - CW'(ys_r[1])) <<< 1;

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    unique case (phase_r)
      PH_IN: begin
        if (accept && few) begin
          push         = 1'b1;
          push_job.emit = 1'b1;
          push_job.few  = 1'b1;
        end else if (accept && pts_r[1]) begin
          push          = 1'b1;
          push_job.a    = xs_r[2];
          push_job.b    = ys_r[2];
          push_job.c    = c_in;
          push_job.e    = e_in;
          push_job.curv = 1'b1;
        end
      end
      PH_END: begin
        push          = !full;
        push_job.a    = xs_r[2];
        push_job.b    = ys_r[2];
        push_job.c    = c_end;
        push_job.e    = e_end;
        push_job.curv = 1'b1;
      end
      PH_FIN: begin
        push          = !full;
        push_job.a    = xs_r[2];
        push_job.b    = ys_r[2];
        push_job.c    = c_fin;
        push_job.e    = e_fin;
        push_job.curv = 1'b1;
        push_job.emit = 1'b1;
      end
      default: begin
        push     = 1'b0;
        push_job = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        xw_r[i] <= '0;
        yw_r[i] <= '0;
        xs_r[i] <= '0;
        ys_r[i] <= '0;
      end
      pts_r   <= '0;
      phase_r <= PH_IN;
    end else if (accept) begin
      if (few) begin
        for (int i = 0; i < 3; i++) begin
          xw_r[i] <= '0;
          yw_r[i] <= '0;
          xs_r[i] <= '0;
          ys_r[i] <= '0;
        end
        pts_r <= '0;
      end else begin
        xw_r[0] <= xw_r[1];
        xw_r[1] <= xw_r[2];
        xw_r[2] <= in_item.x_coord;
        yw_r[0] <= yw_r[1];
        yw_r[1] <= yw_r[2];
        yw_r[2] <= in_item.y_coord;
        if (pts_r != 2'd0) begin
          xs_r[0] <= xs_r[1];
          xs_r[1] <= xs_r[2];
          ys_r[0] <= ys_r[1];
          ys_r[1] <= ys_r[2];
          xs_r[2] <= pts_r[1] ? dx_mid : dx_two;
          ys_r[2] <= pts_r[1] ? dy_mid : dy_two;
        end
        pts_r <= pts_r[1] ? 2'd3 : pts_r + 2'd1;
        if (pts_r[1] && in_item.last_point) begin
          phase_r <= PH_END;
        end
      end
    end else if (phase_r == PH_END && !full) begin
      xs_r[0] <= xs_r[1];
      xs_r[1] <= xs_r[2];
      xs_r[2] <= dx_end;
      ys_r[0] <= ys_r[1];
      ys_r[1] <= ys_r[2];
      ys_r[2] <= dy_end;
      phase_r <= PH_FIN;
    end else if (phase_r == PH_FIN && !full) begin
      for (int i = 0; i < 3; i++) begin
        xw_r[i] <= '0;
        yw_r[i] <= '0;
        xs_r[i] <= '0;
        ys_r[i] <= '0;
      end
      pts_r   <= '0;
      phase_r <= PH_IN;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_needs_three: assert property (@(posedge clk) disable iff (!rst_n)
      (phase_r != PH_IN) |-> (pts_r == 2'd3))
    else $error("end of curve sequence with fewer than three points");
`endif

endmodule

@@ rtl/dcmc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmc_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dcmc_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dcmc_pkg::MCAND_W-1:0]  mcand,
  input  logic [dcmc_pkg::MPLR_W-1:0]   mplr,
  output logic                          done,
  output logic [dcmc_pkg::PROD_W-1:0]   prod
);

  localparam int PW = dcmc_pkg::PROD_W;

  logic [PW-1:0]                 acc_r, mc_r;
  logic [dcmc_pkg::MPLR_W-1:0]   mp_r;
  logic                          run_r, done_r;

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      mc_r  <= PW'(mcand);
      mp_r  <= mplr;
    end else if (run_r && mp_r != '0) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r <= mc_r << 1;
      mp_r <= mp_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && mp_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !run_r)
    else $error("multiplier restarted while busy");
`endif

endmodule

@@ rtl/dcmc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmc_back
// Curvature sequencer: products, exact quotient, integer root, running max.
// ----------------------------------------------------------------------------
module dcmc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  empty,
  input  dcmc_pkg::job_t        pop_job,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dcmc_pkg::out_item_t   out_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // product sequence
  localparam logic [2:0] OP_AE = 3'd0;
  localparam logic [2:0] OP_BC = 3'd1;
  localparam logic [2:0] OP_AA = 3'd2;
  localparam logic [2:0] OP_BB = 3'd3;
  localparam logic [2:0] OP_DD = 3'd4;
  localparam logic [2:0] OP_D3 = 3'd5;
  localparam logic [2:0] OP_NN = 3'd6;

  localparam int PW  = dcmc_pkg::PROD_W;
  localparam int MCW = dcmc_pkg::MCAND_W;
  localparam int MPW = dcmc_pkg::MPLR_W;
  localparam int RW  = dcmc_pkg::RES_W;

  logic [2:0]   state_r, op_r;
  dcmc_pkg::job_t job_r;
  logic [68:0]  p1_r;
  logic         s1_r;
  logic [MPW-1:0] n_r;
  logic [67:0]  d_r;
  logic [135:0] dd_r;
  logic [PW-1:0] d3_r, rem_r;
  logic [63:0]  quo_r;
  logic [35:0]  srem_r;
  logic [31:0]  root_r;
  logic [6:0]   cnt_r;
  logic [RW-1:0] k_r, best_r;
  logic         out_valid_r;
  dcmc_pkg::out_item_t out_item_r;

  logic [33:0]  mag_a, mag_b;
  logic [35:0]  mag_c, mag_e;
  logic         mul_start, mul_done;
  logic [MCW-1:0] mul_mcand;
  logic [MPW-1:0] mul_mplr;
  logic [PW-1:0]  mul_prod;

  logic signed [71:0] sp1, sp2, sdiff;
  logic [67:0]   d_sum;
  logic [PW-1:0] rem_sh;
  logic [35:0]   r4, trial;
  logic [RW-1:0] best_new;
  logic          out_free;

  assign mag_a = job_r.a[33] ? 34'(-job_r.a) : 34'(job_r.a);
  assign mag_b = job_r.b[33] ? 34'(-job_r.b) : 34'(job_r.b);
  assign mag_c = job_r.c[35] ? 36'(-job_r.c) : 36'(job_r.c);
  assign mag_e = job_r.e[35] ? 36'(-job_r.e) : 36'(job_r.e);

  always_comb begin
    mul_mcand = '0;
    mul_mplr  = '0;
    unique case (op_r)
      OP_AE: begin mul_mcand = MCW'(mag_a); mul_mplr = MPW'(mag_e); end
      OP_BC: begin mul_mcand = MCW'(mag_b); mul_mplr = MPW'(mag_c); end
      OP_AA: begin mul_mcand = MCW'(mag_a); mul_mplr = MPW'(mag_a); end
      OP_BB: begin mul_mcand = MCW'(mag_b); mul_mplr = MPW'(mag_b); end
      OP_DD: begin mul_mcand = MCW'(d_r);   mul_mplr = MPW'(d_r);   end
      OP_D3: begin mul_mcand = dd_r;        mul_mplr = MPW'(d_r);   end
      OP_NN: begin mul_mcand = MCW'(n_r);   mul_mplr = n_r;         end
      default: begin mul_mcand = '0; mul_mplr = '0; end
    endcase
  end

  assign mul_start = (state_r == S_MUL);

  dcmc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mcand (mul_mcand),
    .mplr  (mul_mplr),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // N = |a*e - b*c|
  assign sp1   = s1_r ? -$signed(72'(p1_r)) : $signed(72'(p1_r));
  assign sp2   = (job_r.b[33] ^ job_r.c[35]) ? -$signed(72'(mul_prod[68:0]))
                                              : $signed(72'(mul_prod[68:0]));
  assign sdiff = sp1 - sp2;
  assign d_sum = d_r + mul_prod[67:0];

  assign rem_sh = {rem_r[PW-2:0], 1'b0};
  assign r4     = {srem_r[33:0], quo_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};

  assign best_new = (k_r > best_r) ? k_r : best_r;
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (!empty) begin
          job_r <= pop_job;
          k_r   <= '0;
        end
      end
      S_MWAIT: begin
        if (mul_done) begin
          unique case (op_r)
            OP_AE: begin
              p1_r <= mul_prod[68:0];
              s1_r <= job_r.a[33] ^ job_r.e[35];
            end
            OP_BC: n_r  <= sdiff[71] ? MPW'(-sdiff) : MPW'(sdiff);
            OP_AA: d_r  <= mul_prod[67:0];
            OP_BB: d_r  <= d_sum;
            OP_DD: dd_r <= mul_prod[135:0];
            OP_D3: d3_r <= mul_prod;
            OP_NN: begin
              rem_r <= mul_prod;
              cnt_r <= '0;
              if (d3_r <= mul_prod) begin
                k_r <= '1;
              end
            end
            default: p1_r <= p1_r;
          endcase
        end
      end
      S_DIV: begin
        if (rem_sh >= d3_r) begin
          rem_r <= rem_sh - d3_r;
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= (cnt_r == 7'd63) ? '0 : cnt_r + 7'd1;
        srem_r <= '0;
        root_r <= '0;
      end
      S_SQRT: begin
        if (r4 >= trial) begin
          srem_r <= r4 - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= r4;
          root_r <= {root_r[30:0], 1'b0};
        end
        quo_r <= quo_r << 2;
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd31) begin
          k_r <= (r4 >= trial) ? {root_r[30:0], 1'b1} : {root_r[30:0], 1'b0};
        end
      end
      default: k_r <= k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_AE;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!empty) begin
            op_r    <= OP_AE;
            state_r <= pop_job.curv ? S_MUL : S_EMIT;
          end
        end
        S_MUL: state_r <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            if (op_r == OP_BB && d_sum == '0) begin
              state_r <= S_UPD;
            end else if (op_r == OP_NN) begin
              state_r <= (d3_r <= mul_prod) ? S_UPD : S_DIV;
            end else begin
              op_r    <= op_r + 3'd1;
              state_r <= S_MUL;
            end
          end
        end
        S_DIV: begin
          if (cnt_r == 7'd63) begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt_r == 7'd31) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          best_r  <= best_new;
          state_r <= job_r.emit ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            best_r  <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_item_r.max_curvature  <= job_r.few ? '0 : best_r;
      out_item_r.too_few_points <= job_r.few;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_DIV) |-> (rem_r < d3_r))
    else $error("division remainder not below divisor");
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
      mul_done |-> (state_r == S_MWAIT))
    else $error("product arrived outside wait state");
`endif

endmodule

@@ rtl/discrete_curve_max_curvature.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discrete_curve_max_curvature
// Largest finite-difference curvature over a streamed curve, Q16.16 result.
// ----------------------------------------------------------------------------
// Back end: one curvature takes up to seven bit-serial products, then 64 quotient
//   steps and 32 root steps unless the result saturates or D is zero.
// Throughput: one point per curvature time; a last point queues three.
// The front end takes points at once while the job queue has room and no curve end is being queued.
// Reset: synchronous, active low; clears windows, queue, running max, output.
module discrete_curve_max_curvature #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dcmc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dcmc_pkg::out_item_t  out_item
);

  // Front end: keeps the point and slope windows and turns each point into
  // zero to three jobs (curvature, with a flag on the one that ends a curve, or a too-few-points job).
  logic           push, full, pop, empty;
  dcmc_pkg::job_t push_job, pop_job;

  dcmc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  // Queue: decouples point intake from the long curvature evaluation.
  dcmc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  // Back end: exact curvature floor(N*2^32 / D^1.5) as the integer root of
  // floor(N^2*2^64 / D^3), saturating when N^2 >= D^3, zero when D is zero.
  dcmc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
